/* hdl/adsb_vd_pkg.sv */
// Shared types, constants and lookup functions for the ADS-B velocity decoder.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
package adsb_vd_pkg;

    localparam int MSG_W    = 56;
    localparam int SPEED_W  = 14;
    localparam int DIR_W    = 16;
    localparam int CODE_W   = 10;
    localparam int HK_W     = 11;
    localparam int COMP_W   = 13;
    localparam int SQ_W     = 26;
    localparam int SUM_W    = 28;
    localparam int CORD_W   = 47;
    localparam int ANG_W    = 33;
    localparam int ATAN_W   = 30;
    localparam int FRAC_W   = 30;
    localparam int ZC_W     = 31;
    localparam int PROD_W   = 63;
    localparam int FULL_W   = 33;
    localparam int CELLS    = 28;
    localparam int IDX_W    = 5;

    localparam logic [IDX_W-1:0]  SQRT_STEPS      = 5'd14;
    localparam logic [SUM_W-1:0]  SQRT_TOP        = 28'h4000000;
    localparam logic [ZC_W-1:0]   HALF_PI_Q30     = 31'd1686629713;
    localparam logic [31:0]       TWO_OVER_PI_Q32 = 32'hA2F9836E;
    localparam logic [ZC_W-1:0]   QUARTER_TURN    = 31'h40000000;
    localparam logic [FULL_W-1:0] HALF_TURN       = 33'h080000000;
    localparam logic [FULL_W-1:0] FULL_TURN       = 33'h100000000;
    localparam logic [FULL_W-1:0] ROUND_BIAS      = 33'h000008000;

    localparam logic [CODE_W-1:0] CODE_NONE = 10'd0;
    localparam logic [CODE_W-1:0] CODE_MAX  = 10'd1023;
    localparam logic [HK_W-1:0]   HK_MAX    = 11'd2043;

    localparam logic [2:0] SUB_GND_NORMAL = 3'd1;
    localparam logic [2:0] SUB_GND_SUPER  = 3'd2;
    localparam logic [2:0] SUB_AIR_SUPER  = 3'd4;

    // Quadrant select, {west, south}.
    localparam logic [1:0] QUAD_NE = 2'b00;
    localparam logic [1:0] QUAD_SE = 2'b01;
    localparam logic [1:0] QUAD_NW = 2'b10;
    localparam logic [1:0] QUAD_SW = 2'b11;

    typedef struct packed {
        logic              air_mode;
        logic              unavail;
        logic              west;
        logic              south;
        logic              e_zero;
        logic              n_zero;
        logic [SPEED_W-1:0] air_speed;
        logic [DIR_W-1:0]  air_dir;
    } meta_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic [SUM_W-1:0]         rem;
        logic [SUM_W-1:0]         root;
        meta_t                    meta;
    } stage_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIR_W-1:0]   direction;
        logic               air_mode;
        logic               unavail;
    } result_t;

    function automatic logic [HK_W-1:0] code_to_half_knots(input logic [CODE_W-1:0] code);
        logic [HK_W-1:0] hk;
        if (code == CODE_NONE)
        begin
            hk = '0;
        end
        else if (code == CODE_MAX)
        begin
            hk = HK_MAX;
        end
        else
        begin
            hk = {code - 10'd1, 1'b0};
        end
        return hk;
    endfunction

    // Arctangent of 2^-i in Q30 radians, truncated (the last entry is rounded up).
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic [ATAN_W-1:0] a;
        case (idx)
            5'd0:    a = 30'h3243F6A8;
            5'd1:    a = 30'h1DAC6705;
            5'd2:    a = 30'h0FADBAFC;
            5'd3:    a = 30'h07F56EA6;
            5'd4:    a = 30'h03FEAB76;
            5'd5:    a = 30'h01FFD55B;
            5'd6:    a = 30'h00FFFAAA;
            5'd7:    a = 30'h007FFF55;
            5'd8:    a = 30'h003FFFEA;
            5'd9:    a = 30'h001FFFFD;
            5'd10:   a = 30'h000FFFFF;
            5'd11:   a = 30'h0007FFFF;
            5'd12:   a = 30'h0003FFFF;
            5'd13:   a = 30'h0001FFFF;
            5'd14:   a = 30'h0000FFFF;
            5'd15:   a = 30'h00007FFF;
            5'd16:   a = 30'h00003FFF;
            5'd17:   a = 30'h00001FFF;
            5'd18:   a = 30'h00000FFF;
            5'd19:   a = 30'h000007FF;
            5'd20:   a = 30'h000003FF;
            5'd21:   a = 30'h000001FF;
            5'd22:   a = 30'h000000FF;
            5'd23:   a = 30'h0000007F;
            5'd24:   a = 30'h0000003F;
            5'd25:   a = 30'h0000001F;
            5'd26:   a = 30'h0000000F;
            5'd27:   a = 30'h00000008;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/adsb_vd_if.sv */
// Valid/ready channel interfaces for the message input and the decoded result output.
// Depends on adsb_vd_pkg for field widths.
interface adsb_vd_in_if;
    logic                           valid;
    logic                           ready;
    logic [adsb_vd_pkg::MSG_W-1:0]  message_bits;

    modport source (output valid, output message_bits, input ready);
    modport sink (input valid, input message_bits, output ready);
endinterface

interface adsb_vd_out_if;
    logic                             valid;
    logic                             ready;
    logic [adsb_vd_pkg::SPEED_W-1:0]  speed_half_knots;
    logic [adsb_vd_pkg::DIR_W-1:0]    direction;
    logic                             airspeed_mode;
    logic                             speed_unavailable;

    modport source (output valid, output speed_half_knots, output direction,
                    output airspeed_mode, output speed_unavailable, input ready);
    modport sink (input valid, input speed_half_knots, input direction,
                  input airspeed_mode, input speed_unavailable, output ready);
endinterface

/* hdl/adsb_vd_decode.sv */
// Front stage: splits the message into fields, converts speed codes and seeds the cell chain.
// Depends on adsb_vd_pkg.
module adsb_vd_decode (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [adsb_vd_pkg::MSG_W-1:0]  message_bits,
    output logic                           out_valid,
    output adsb_vd_pkg::stage_t            out_stage
);

    logic                               valid_reg;
    adsb_vd_pkg::stage_t                stage_reg;
    adsb_vd_pkg::stage_t                stage_next;

    logic [2:0]                         sub;
    logic [adsb_vd_pkg::CODE_W-1:0]     c1;
    logic [adsb_vd_pkg::CODE_W-1:0]     c2;
    logic [adsb_vd_pkg::HK_W-1:0]       hk1;
    logic [adsb_vd_pkg::HK_W-1:0]       hk2;
    logic                               gnd;
    logic                               super_gnd;
    logic [adsb_vd_pkg::COMP_W-1:0]     e;
    logic [adsb_vd_pkg::COMP_W-1:0]     n;
    logic [adsb_vd_pkg::COMP_W-1:0]     air;
    logic [adsb_vd_pkg::SQ_W-1:0]       e_sq;
    logic [adsb_vd_pkg::SQ_W-1:0]       n_sq;

    always_comb
    begin
        sub = message_bits[50:48];
        c1  = message_bits[41:32];
        c2  = message_bits[30:21];
        hk1 = adsb_vd_pkg::code_to_half_knots(c1);
        hk2 = adsb_vd_pkg::code_to_half_knots(c2);
        gnd = (sub == adsb_vd_pkg::SUB_GND_NORMAL) || (sub == adsb_vd_pkg::SUB_GND_SUPER);
        super_gnd = (sub == adsb_vd_pkg::SUB_GND_SUPER);
        e = super_gnd ? {hk1, 2'b00} : {2'b00, hk1};
        n = super_gnd ? {hk2, 2'b00} : {2'b00, hk2};
        air = (sub == adsb_vd_pkg::SUB_AIR_SUPER) ? {hk2, 2'b00} : {2'b00, hk2};
        e_sq = {13'd0, e} * {13'd0, e};
        n_sq = {13'd0, n} * {13'd0, n};

        stage_next.x    = $signed({4'd0, n, 30'd0});
        stage_next.y    = $signed({4'd0, e, 30'd0});
        stage_next.z    = '0;
        stage_next.rem  = {2'b00, e_sq} + {2'b00, n_sq};
        stage_next.root = '0;
        stage_next.meta.air_mode  = !gnd;
        stage_next.meta.unavail   = gnd ? ((c1 == adsb_vd_pkg::CODE_NONE) ||
                                           (c2 == adsb_vd_pkg::CODE_NONE))
                                        : (c2 == adsb_vd_pkg::CODE_NONE);
        stage_next.meta.west      = message_bits[42];
        stage_next.meta.south     = message_bits[31];
        // A component is zero both when unavailable and when its code means zero knots.
        stage_next.meta.e_zero    = (hk1 == '0);
        stage_next.meta.n_zero    = (hk2 == '0);
        stage_next.meta.air_speed = {1'b0, air};
        stage_next.meta.air_dir   = {c1, 6'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

/* hdl/adsb_vd_cell.sv */
// One cell of the chain: one CORDIC vectoring rotation and, in the first cells,
// one digit of the square root. Depends on adsb_vd_pkg.
module adsb_vd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [adsb_vd_pkg::IDX_W-1:0]  idx,
    input  logic                           in_valid,
    input  adsb_vd_pkg::stage_t            in_stage,
    output logic                           out_valid,
    output adsb_vd_pkg::stage_t            out_stage
);

    logic                                   valid_reg;
    adsb_vd_pkg::stage_t                    stage_reg;
    adsb_vd_pkg::stage_t                    stage_next;

    logic signed [adsb_vd_pkg::CORD_W-1:0]  dx;
    logic signed [adsb_vd_pkg::CORD_W-1:0]  dy;
    logic signed [adsb_vd_pkg::ANG_W-1:0]   ang;
    logic [adsb_vd_pkg::SUM_W-1:0]          sbit;
    logic [adsb_vd_pkg::SUM_W:0]            trial;

    always_comb
    begin
        stage_next = in_stage;
        dx    = in_stage.y >>> idx;
        dy    = in_stage.x >>> idx;
        ang   = $signed({3'b000, adsb_vd_pkg::atan_q30(idx)});
        sbit  = adsb_vd_pkg::SQRT_TOP >> {idx, 1'b0};
        trial = {1'b0, in_stage.root} + {1'b0, sbit};

        // Rotate toward the x axis; the sign of y picks the direction.
        if (!in_stage.y[adsb_vd_pkg::CORD_W-1])
        begin
            stage_next.x = in_stage.x + dx;
            stage_next.y = in_stage.y - dy;
            stage_next.z = in_stage.z + ang;
        end
        else
        begin
            stage_next.x = in_stage.x - dx;
            stage_next.y = in_stage.y + dy;
            stage_next.z = in_stage.z - ang;
        end

        if (idx < adsb_vd_pkg::SQRT_STEPS)
        begin
            if ({1'b0, in_stage.rem} >= trial)
            begin
                stage_next.rem  = in_stage.rem - trial[adsb_vd_pkg::SUM_W-1:0];
                stage_next.root = (in_stage.root >> 1) + sbit;
            end
            else
            begin
                stage_next.root = in_stage.root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

/* hdl/adsb_vd_finish.sv */
// Back end of the chain: angle scaling to turns, quadrant placement, rounding of
// speed and heading, and mode selection. Two register stages. Depends on adsb_vd_pkg.
module adsb_vd_finish (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  adsb_vd_pkg::stage_t  in_stage,
    output logic                 out_valid,
    output adsb_vd_pkg::result_t out_result
);

    logic                               s1_valid_reg;
    logic [adsb_vd_pkg::ZC_W-1:0]       s1_q_reg;
    logic [adsb_vd_pkg::SPEED_W-1:0]    s1_speed_reg;
    adsb_vd_pkg::meta_t                 s1_meta_reg;
    logic                               s2_valid_reg;
    adsb_vd_pkg::result_t               s2_result_reg;

    logic [adsb_vd_pkg::ZC_W-1:0]       zc;
    logic [adsb_vd_pkg::PROD_W-1:0]     prod;
    logic [adsb_vd_pkg::SPEED_W-1:0]    speed_next;
    logic [adsb_vd_pkg::ZC_W-1:0]       qsel;
    logic [adsb_vd_pkg::FULL_W-1:0]     q_ext;
    logic [adsb_vd_pkg::FULL_W-1:0]     full;
    logic [adsb_vd_pkg::FULL_W-1:0]     rnd;
    logic [adsb_vd_pkg::DIR_W-1:0]      gnd_dir;
    adsb_vd_pkg::result_t               result_next;

    always_comb
    begin
        if (in_stage.z[adsb_vd_pkg::ANG_W-1])
        begin
            zc = '0;
        end
        else if (in_stage.z[adsb_vd_pkg::ANG_W-2:0] > {1'b0, adsb_vd_pkg::HALF_PI_Q30})
        begin
            zc = adsb_vd_pkg::HALF_PI_Q30;
        end
        else
        begin
            zc = in_stage.z[adsb_vd_pkg::ZC_W-1:0];
        end
        prod = zc * adsb_vd_pkg::TWO_OVER_PI_Q32;
        speed_next = in_stage.root[adsb_vd_pkg::SPEED_W-1:0]
                   + {13'd0, (in_stage.rem > in_stage.root)};
    end

    always_comb
    begin
        if (s1_meta_reg.e_zero)
        begin
            qsel = '0;
        end
        else if (s1_meta_reg.n_zero)
        begin
            qsel = adsb_vd_pkg::QUARTER_TURN;
        end
        else
        begin
            qsel = s1_q_reg;
        end
        q_ext = {2'b00, qsel};

        case ({s1_meta_reg.west, s1_meta_reg.south})
            adsb_vd_pkg::QUAD_NE: full = q_ext;
            adsb_vd_pkg::QUAD_SE: full = adsb_vd_pkg::HALF_TURN - q_ext;
            adsb_vd_pkg::QUAD_NW: full = adsb_vd_pkg::FULL_TURN - q_ext;
            adsb_vd_pkg::QUAD_SW: full = adsb_vd_pkg::HALF_TURN + q_ext;
            default:              full = q_ext;
        endcase

        // A full turn rounds to zero by dropping the bit above the heading.
        rnd = full + adsb_vd_pkg::ROUND_BIAS;
        gnd_dir = (s1_meta_reg.e_zero && s1_meta_reg.n_zero) ? '0 : rnd[31:16];

        result_next.air_mode  = s1_meta_reg.air_mode;
        result_next.unavail   = s1_meta_reg.unavail;
        result_next.speed     = s1_meta_reg.air_mode ? s1_meta_reg.air_speed : s1_speed_reg;
        result_next.direction = s1_meta_reg.air_mode ? s1_meta_reg.air_dir : gnd_dir;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_q_reg      <= prod[adsb_vd_pkg::PROD_W-1:32];
            s1_speed_reg  <= speed_next;
            s1_meta_reg   <= in_stage.meta;
            s2_result_reg <= result_next;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_result = s2_result_reg;

endmodule

/* hdl/adsb_vd_outbuf.sv */
// Output register with one skid entry, so the chain keeps moving while a result waits.
// Depends on adsb_vd_pkg and adsb_vd_out_if.
module adsb_vd_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  adsb_vd_pkg::result_t  in_result,
    output logic                  advance,
    adsb_vd_out_if.source         out_ch
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    adsb_vd_pkg::result_t  out_data_reg;
    adsb_vd_pkg::result_t  out_data_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    adsb_vd_pkg::result_t  skid_data_reg;
    adsb_vd_pkg::result_t  skid_data_next;
    logic                  take;
    logic                  slot_free;

    // The chain only advances while the skid entry is empty, so a beat is never dropped.
    assign advance   = !skid_valid_reg;
    assign take      = advance && in_valid;
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_ch.ready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (take)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_result;
            end
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.speed_half_knots  = out_data_reg.speed;
    assign out_ch.direction         = out_data_reg.direction;
    assign out_ch.airspeed_mode     = out_data_reg.air_mode;
    assign out_ch.speed_unavailable = out_data_reg.unavail;

endmodule

/* hdl/adsb_velocity_decode_unit.sv */
// ADS-B airborne velocity decoder: decode stage, a chain of 28 CORDIC/square-root cells,
// a two-stage finish and an output register with skid entry.
// A message passes the decode register, the cell registers, both finish registers and the output register.
// Throughput: one message per cycle; the chain stalls only while the skid entry is full.
// Reset (rst_n, asynchronous, active low) empties every stage; no results are pending.
module adsb_velocity_decode_unit (
    input  logic          clk,
    input  logic          rst_n,
    adsb_vd_in_if.sink    msg,
    adsb_vd_out_if.source result
);

    logic                  advance;
    logic                  chain_valid [adsb_vd_pkg::CELLS+1];
    adsb_vd_pkg::stage_t   chain_stage [adsb_vd_pkg::CELLS+1];
    logic                  fin_valid;
    adsb_vd_pkg::result_t  fin_result;

    assign msg.ready = advance;

    adsb_vd_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .in_valid     (msg.valid),
        .message_bits (msg.message_bits),
        .out_valid    (chain_valid[0]),
        .out_stage    (chain_stage[0])
    );

    for (genvar g = 0; g < adsb_vd_pkg::CELLS; g++)
    begin : g_cell
        adsb_vd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .idx       (adsb_vd_pkg::IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_stage  (chain_stage[g]),
            .out_valid (chain_valid[g+1]),
            .out_stage (chain_stage[g+1])
        );
    end

    adsb_vd_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (chain_valid[adsb_vd_pkg::CELLS]),
        .in_stage   (chain_stage[adsb_vd_pkg::CELLS]),
        .out_valid  (fin_valid),
        .out_result (fin_result)
    );

    adsb_vd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fin_valid),
        .in_result (fin_result),
        .advance   (advance),
        .out_ch    (result)
    );

endmodule

/* hdl/adsb_vd_checker.sv */
// Port-level checks for the velocity decoder, attached to the top level by bind.
// Depends on adsb_vd_pkg for field widths.
module adsb_vd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [adsb_vd_pkg::SPEED_W-1:0]  speed_half_knots,
    input logic [adsb_vd_pkg::DIR_W-1:0]    direction,
    input logic                             airspeed_mode,
    input logic                             speed_unavailable
);

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(speed_half_knots) && $stable(direction)
            && $stable(airspeed_mode) && $stable(speed_unavailable))
        else $error("result payload changed while stalled");

    // Heading codes step by 360/1024 degrees in airspeed mode.
    a_air_dir: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && airspeed_mode |-> direction[5:0] == 6'd0)
        else $error("airspeed heading not a multiple of the code step");

    // A zero ground vector has no heading.
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !airspeed_mode && speed_half_knots == '0 |-> direction == '0)
        else $error("zero ground vector with nonzero heading");

    a_air_unavail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && airspeed_mode && speed_unavailable |-> speed_half_knots == '0)
        else $error("unavailable airspeed reported as nonzero");

endmodule

bind adsb_velocity_decode_unit adsb_vd_checker u_adsb_vd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .speed_half_knots  (result.speed_half_knots),
    .direction         (result.direction),
    .airspeed_mode     (result.airspeed_mode),
    .speed_unavailable (result.speed_unavailable)
);

/* tb/tb_top.sv */
// Self-checking testbench for adsb_velocity_decode_unit: directed and random velocity messages.
// A scoreboard class predicts each decoded beat; depends on adsb_vd_pkg and adsb_vd_if.
`timescale 1ns / 1ps

module tb_top;

    import adsb_vd_pkg::*;

    localparam logic [4:0] TC_VELOCITY = 5'd19;
    localparam logic [2:0] SUB_RSVD_0 = 3'd0;
    localparam logic [2:0] SUB_AIR_NORMAL = 3'd3;
    localparam logic [2:0] SUB_RSVD_5 = 3'd5;
    localparam logic [2:0] SUB_RSVD_6 = 3'd6;
    localparam logic [2:0] SUB_RSVD_7 = 3'd7;
    localparam logic [CODE_W-1:0] CODE_STILL = 10'd1;
    localparam int RANDOM_MESSAGES = 550;
    localparam int HOLD_CYCLES = 160;
    localparam int DRAIN_CYCLES = 40;

    class velocity_scoreboard;
        localparam longint HALF_PI = 64'd1686629713;
        localparam longint unsigned TWO_OVER_PI = 64'hA2F9836E;

        longint arctan_q30[28] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008
        };

        result_t decoded_q[$];
        int unsigned n_errors = 0;
        int unsigned n_ground = 0;
        int unsigned n_air = 0;
        int unsigned n_missing = 0;

        function int unsigned code_half_knots(input logic [CODE_W-1:0] code, inout bit missing);
            if (code == CODE_NONE)
            begin
                missing = 1'b1;
                return 0;
            end
            if (code == CODE_MAX)
                return 2043;
            return 2 * (int'(code) - 1);
        endfunction

        // Bitwise integer square root, then rounded to nearest.
        function longint unsigned round_sqrt(input longint unsigned s);
            longint unsigned r;
            longint unsigned b;
            longint unsigned rem;
            r = 0;
            b = 64'd1 << 30;
            rem = s;
            while (b > rem)
                b = b >> 2;
            while (b != 0)
            begin
                if (rem >= r + b)
                begin
                    rem = rem - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (s - r * r > r)
                r = r + 1;
            return r;
        endfunction

        // First-quadrant angle of (e, n) in 2^-32 turn, by CORDIC vectoring in Q30 radians.
        function longint unsigned vector_angle(input int unsigned e, input int unsigned n);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            x = longint'(n) << 30;
            y = longint'(e) << 30;
            z = 0;
            for (int i = 0; i < 28; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + arctan_q30[i];
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - arctan_q30[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > HALF_PI)
                z = HALF_PI;
            return (longint'(z) * TWO_OVER_PI) >> 32;
        endfunction

        function result_t predict_velocity(input logic [MSG_W-1:0] m);
            result_t r;
            logic [2:0] sub;
            logic [1:0] quad;
            bit missing;
            int unsigned e;
            int unsigned n;
            longint unsigned speed;
            longint unsigned q;
            longint unsigned full;
            sub = m[50:48];
            quad = {m[42], m[31]};
            missing = 1'b0;
            if (sub == SUB_GND_NORMAL || sub == SUB_GND_SUPER)
            begin
                e = code_half_knots(m[41:32], missing);
                n = code_half_knots(m[30:21], missing);
                if (sub == SUB_GND_SUPER)
                begin
                    e = e * 4;
                    n = n * 4;
                end
                speed = round_sqrt(longint'(e) * e + longint'(n) * n);
                r.air_mode = 1'b0;
                if (e == 0 && n == 0)
                begin
                    r.direction = '0;
                end
                else
                begin
                    if (e == 0)
                        q = 0;
                    else if (n == 0)
                        q = 64'd1 << 30;
                    else
                        q = vector_angle(e, n);
                    case (quad)
                        QUAD_NE: full = q;
                        QUAD_SE: full = (64'd1 << 31) - q;
                        QUAD_NW: full = (64'd1 << 32) - q;
                        default: full = (64'd1 << 31) + q;
                    endcase
                    full = (full + 64'h8000) >> 16;
                    r.direction = full[15:0];
                end
            end
            else
            begin
                speed = code_half_knots(m[30:21], missing);
                if (sub == SUB_AIR_SUPER)
                    speed = speed * 4;
                r.direction = {m[41:32], 6'b0};
                r.air_mode = 1'b1;
            end
            r.speed = speed[SPEED_W-1:0];
            r.unavail = missing;
            return r;
        endfunction

        function void note_message(input logic [MSG_W-1:0] m);
            decoded_q.push_back(predict_velocity(m));
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (decoded_q.size() == 0)
            begin
                $error("result beat with nothing expected: speed %0d direction %0d",
                       got.speed, got.direction);
                n_errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.speed !== want.speed)
            begin
                $error("speed_half_knots: expected %0d, actual %0d", want.speed, got.speed);
                n_errors++;
            end
            if (got.direction !== want.direction)
            begin
                $error("direction: expected %0d, actual %0d", want.direction, got.direction);
                n_errors++;
            end
            if (got.air_mode !== want.air_mode)
            begin
                $error("airspeed_mode: expected %0d, actual %0d", want.air_mode, got.air_mode);
                n_errors++;
            end
            if (got.unavail !== want.unavail)
            begin
                $error("speed_unavailable: expected %0d, actual %0d", want.unavail, got.unavail);
                n_errors++;
            end
            if (want.air_mode)
                n_air++;
            else
                n_ground++;
            if (want.unavail)
                n_missing++;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit hold_req = 1'b0;
    bit steady = 1'b0;

    velocity_scoreboard sb = new();

    adsb_vd_in_if in_ch();
    adsb_vd_out_if out_ch();

    adsb_velocity_decode_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (in_ch),
        .result (out_ch)
    );

    always #4 clk = ~clk;

    function automatic logic [MSG_W-1:0] build_msg(input logic [4:0] tc, input logic [2:0] sub,
                                                   input logic west, input logic [9:0] c1,
                                                   input logic south, input logic [9:0] c2);
        logic [MSG_W-1:0] m;
        m = '0;
        m[55:51] = tc;
        m[50:48] = sub;
        m[42] = west;
        m[41:32] = c1;
        m[31] = south;
        m[30:21] = c2;
        return m;
    endfunction

    // Mostly uniform codes, with the corner codes drawn more often.
    function automatic logic [CODE_W-1:0] pick_code();
        logic [CODE_W-1:0] corners[5];
        corners = '{CODE_NONE, CODE_STILL, 10'd2, 10'd1022, CODE_MAX};
        if ($urandom_range(99) < 15)
            return corners[$urandom_range(4)];
        return $urandom_range(1023);
    endfunction

    function automatic logic [MSG_W-1:0] random_message();
        logic [MSG_W-1:0] m;
        logic [2:0] reserved[5];
        int pick;
        reserved = '{SUB_RSVD_0, SUB_AIR_NORMAL, SUB_RSVD_5, SUB_RSVD_6, SUB_RSVD_7};
        m[55:32] = $urandom;
        m[31:0] = $urandom;
        pick = $urandom_range(99);
        if (pick < 40)
            m[50:48] = SUB_GND_NORMAL;
        else if (pick < 65)
            m[50:48] = SUB_GND_SUPER;
        else if (pick < 80)
            m[50:48] = SUB_AIR_SUPER;
        else
            m[50:48] = reserved[$urandom_range(4)];
        m[41:32] = pick_code();
        m[30:21] = pick_code();
        return m;
    endfunction

    task automatic send_message(input logic [MSG_W-1:0] m);
        in_ch.valid <= 1'b1;
        in_ch.message_bits <= m;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_message(m);
        // Short gaps now and then keep the sender idle in roughly an eighth of the cycles.
        if (!steady && $urandom_range(99) < 4)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        in_ch.valid <= 1'b0;
        in_ch.message_bits <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero components, the axes, the wrap to north, the corner codes, airspeed and reserved subtypes.
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b0, CODE_NONE, 1'b0, CODE_NONE));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b1, CODE_STILL, 1'b1, CODE_STILL));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b0, CODE_STILL, 1'b1, 10'd500));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b1, 10'd700, 1'b0, CODE_STILL));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b1, CODE_STILL, 1'b0, 10'd300));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b0, CODE_MAX, 1'b0, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b0, CODE_MAX, 1'b1, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b1, CODE_MAX, 1'b0, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b1, CODE_MAX, 1'b1, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_SUPER, 1'b1, CODE_MAX, 1'b1, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_SUPER, 1'b0, CODE_NONE, 1'b1, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_NORMAL, 1'b1, 10'd2, 1'b0, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_GND_SUPER, 1'b0, 10'd1022, 1'b1, 10'd2));
        send_message(build_msg(TC_VELOCITY, SUB_RSVD_0, 1'b1, CODE_MAX, 1'b1, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_AIR_NORMAL, 1'b0, CODE_NONE, 1'b0, CODE_NONE));
        send_message(build_msg(TC_VELOCITY, SUB_AIR_SUPER, 1'b1, CODE_MAX, 1'b0, CODE_MAX));
        send_message(build_msg(TC_VELOCITY, SUB_AIR_SUPER, 1'b0, 10'd512, 1'b1, CODE_NONE));
        send_message(build_msg(TC_VELOCITY, SUB_RSVD_5, 1'b0, CODE_STILL, 1'b0, 10'd1022));
        send_message(build_msg(TC_VELOCITY, SUB_RSVD_6, 1'b1, CODE_MAX, 1'b1, 10'd2));
        send_message(build_msg(TC_VELOCITY, SUB_RSVD_7, 1'b0, 10'd300, 1'b0, CODE_MAX));
        send_message(build_msg(5'h1F, SUB_GND_NORMAL, 1'b1, 10'd345, 1'b1, 10'd678));
        send_message(build_msg(5'h00, SUB_GND_SUPER, 1'b0, 10'd1, 1'b0, 10'd1023));
        send_message({MSG_W{1'b1}});
        send_message('0);

        for (int i = 0; i < RANDOM_MESSAGES; i++)
        begin
            if (i == 100)
                hold_req = 1'b1;
            steady = (i >= 200 && i < 330);
            if (i == 400)
            begin
                // Let the pipeline run dry before carrying on.
                in_ch.valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_message(random_message());
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d ground vector and %0d airspeed beats checked, %0d flagged unavailable",
                 sb.n_ground, sb.n_air, sb.n_missing);
        $display("summary: %0d mismatches or stray beats", sb.n_errors);
        if (sb.n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Result side: checks each beat, applies random back-pressure and one long hold-off.
    initial
    begin
        int hold_left;
        bit hold_done;
        result_t got;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.speed = out_ch.speed_half_knots;
                got.direction = out_ch.direction;
                got.air_mode = out_ch.airspeed_mode;
                got.unavail = out_ch.speed_unavailable;
                sb.check_result(got);
            end
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= 13);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
